// ----- rtl/ppp_pkg.sv -----
package ppp_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic [9:0] PATIENCE_RESET = 10'd30;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [39:0] PI_Q30      = 40'sd3373259426;
  localparam logic signed [39:0] TWO_PI_Q30  = 40'sd6746518852;
  localparam logic signed [39:0] HALF_PI_Q30 = 40'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] kappa;
    logic signed [31:0] heading;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } trig_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd843314856;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043836;
      5'd3:  a = 34'sd133525158;
      5'd4:  a = 34'sd67021686;
      5'd5:  a = 34'sd33543515;
      5'd6:  a = 34'sd16775850;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194282;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048575;
      5'd11: a = 34'sd524287;
      5'd12: a = 34'sd262143;
      5'd13: a = 34'sd131071;
      5'd14: a = 34'sd65535;
      5'd15: a = 34'sd32767;
      5'd16: a = 34'sd16383;
      5'd17: a = 34'sd8191;
      5'd18: a = 34'sd4095;
      5'd19: a = 34'sd2047;
      5'd20: a = 34'sd1023;
      5'd21: a = 34'sd511;
      5'd22: a = 34'sd255;
      5'd23: a = 34'sd127;
      5'd24: a = 34'sd63;
      5'd25: a = 34'sd31;
      5'd26: a = 34'sd15;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ppp_store.sv -----
module ppp_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ppp_pkg::point_t   wr_data,
  input  logic [AW-1:0]     rd_addr,
  output ppp_pkg::point_t   rd_data
);

  ppp_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/ppp_cordic.sv -----
module ppp_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] heading,
  output ppp_pkg::trig_t     trig
);

  typedef enum logic [1:0] {C_IDLE, C_REDUCE, C_FOLD, C_ITER} cstate_t;

  cstate_t            state;
  logic signed [39:0] r;
  logic               neg;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [4:0]         step;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = ppp_pkg::atan_q30(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      trig.done <= 1'b0;
    end else begin
      trig.done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            r     <= 40'(heading) <<< 6;
            neg   <= 1'b0;
            state <= C_REDUCE;
          end
        end
        // bring the angle into [-pi, pi) one turn a cycle
        C_REDUCE: begin
          if (r >= ppp_pkg::PI_Q30) begin
            r <= r - ppp_pkg::TWO_PI_Q30;
          end else if (r < -ppp_pkg::PI_Q30) begin
            r <= r + ppp_pkg::TWO_PI_Q30;
          end else begin
            state <= C_FOLD;
          end
        end
        C_FOLD: begin
          x    <= ppp_pkg::GAIN_Q30;
          y    <= '0;
          step <= '0;
          if (r > ppp_pkg::HALF_PI_Q30) begin
            z   <= 34'(r - ppp_pkg::PI_Q30);
            neg <= 1'b1;
          end else if (r < -ppp_pkg::HALF_PI_Q30) begin
            z   <= 34'(r + ppp_pkg::PI_Q30);
            neg <= 1'b1;
          end else begin
            z <= r[33:0];
          end
          state <= C_ITER;
        end
        C_ITER: begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (step == 5'(ppp_pkg::CORDIC_STEPS - 1)) begin
            trig.done <= 1'b1;
            // outputs follow the final rotation; read only with done
            if (z >= 0) begin
              trig.cos_v <= neg ? -(x - ys) : (x - ys);
              trig.sin_v <= neg ? -(y + xs) : (y + xs);
            end else begin
              trig.cos_v <= neg ? -(x + ys) : (x + ys);
              trig.sin_v <= neg ? -(y - xs) : (y - xs);
            end
            state     <= C_IDLE;
          end
          step <= step + 5'd1;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/path_match_point_projection.sv -----
// Load: s_tready stays high while idle, so loads are accepted back to back.
// Query: a scan reading one stored point per cycle until the patience limit stops it or
// all N points are visited, a fetch of the match, angle reduction, CORDIC, the steps on
// the shared multiplier and presenting the result; not ready meanwhile.
// Reset clears point count, overflow flag, output valid and sets patience to 30;
// the point store itself is not cleared.
module path_match_point_projection #(
  parameter int MAX_POINTS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [9:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // pos_x, pos_y, point_heading, point_kappa
  input  logic [1:0]   s_tuser,   // cmd, restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [239:0] m_tdata,   // match_index, match_x, match_y, match_heading,
                                  // proj_x, proj_y, proj_heading, proj_kappa, pad
  output logic [1:0]   m_tuser    // valid_res, truncated
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_FETCH, ST_LATCH, ST_TRIG, ST_MDX, ST_MDY,
    ST_TSUM, ST_MTC, ST_MTS, ST_MMAG, ST_PH, ST_OUT
  } state_t;

  state_t             state;
  logic [CW-1:0]      point_count;
  logic               overflow_flag;
  logic [9:0]         search_patience;
  logic signed [31:0] qx;
  logic signed [31:0] qy;

  logic [CW-1:0]      ia;
  logic               stop;
  logic [10:0]        cnt;
  logic [AW-1:0]      best_idx;
  logic [66:0]        best_dist;
  logic               rv1;
  logic [AW-1:0]      ri1;
  logic               rv2;
  logic [AW-1:0]      ri2;
  logic [65:0]        sq_x;
  logic [65:0]        sq_y;

  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic signed [31:0] mh;
  logic signed [31:0] mk;
  logic signed [30:0] c28;
  logic signed [30:0] s28;
  logic signed [69:0] acc;
  logic signed [35:0] t16;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               res_valid;

  logic               accept;
  logic               is_load;
  logic [CW-1:0]      cnt_eff;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  ppp_pkg::point_t    wr_data;
  ppp_pkg::point_t    rd_data;
  logic               issue;
  logic signed [32:0] dxs;
  logic signed [32:0] dys;
  logic [32:0]        ax;
  logic [32:0]        ay;
  logic [66:0]        sq_dist;
  logic               improve;
  logic [10:0]        cnt_new;
  logic               trig_start;
  ppp_pkg::trig_t     trig;

  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod;
  logic signed [70:0] tsum;
  logic signed [71:0] px_sum;
  logic signed [71:0] py_sum;
  logic [71:0]        hterm;
  logic signed [71:0] ph_sum;
  logic [31:0]        idx_ext;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (s_tuser[0] == ppp_pkg::CMD_LOAD);
  assign cnt_eff  = s_tuser[1] ? '0 : point_count;
  assign wr_en    = accept && is_load && (cnt_eff < CW'(MAX_POINTS));
  assign wr_data  = ppp_pkg::point_t'(s_tdata);
  assign rd_addr  = (state == ST_SEARCH) ? ia[AW-1:0] : best_idx;
  assign issue    = (state == ST_SEARCH) && !stop && (ia < point_count);

  ppp_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_eff[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign trig_start = (state == ST_LATCH);

  ppp_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .heading (rd_data.heading),
    .trig    (trig)
  );

  // scan datapath
  assign dxs     = 33'(rd_data.x) - 33'(qx);
  assign dys     = 33'(rd_data.y) - 33'(qy);
  assign ax      = dxs[32] ? 33'(-dxs) : 33'(dxs);
  assign ay      = dys[32] ? 33'(-dys) : 33'(dys);
  assign sq_dist = 67'(sq_x) + 67'(sq_y);
  assign improve = (ri2 == '0) || (sq_dist < best_dist);
  assign cnt_new = improve ? 11'd1 : cnt + 11'd1;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MDX: begin
        mul_a = 36'(33'(qx) - 33'(mx));
        mul_b = 34'(c28);
      end
      ST_MDY: begin
        mul_a = 36'(33'(qy) - 33'(my));
        mul_b = 34'(s28);
      end
      ST_MTC: begin
        mul_a = t16;
        mul_b = 34'(c28);
      end
      ST_MTS: begin
        mul_a = t16;
        mul_b = 34'(s28);
      end
      ST_MMAG: begin
        mul_a = t16[35] ? -t16 : t16;
        mul_b = mk[31] ? -34'(mk) : 34'(mk);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    sq_x <= ax * ax;
    sq_y <= ay * ay;
  end

  assign tsum   = 71'(acc) + 71'(prod) + 71'(29'sd134217728);
  assign px_sum = 72'(mx) + ((72'(prod) + 72'(29'sd134217728)) >>> 28);
  assign py_sum = 72'(my) + ((72'(prod) + 72'(29'sd134217728)) >>> 28);
  assign hterm  = 72'(prod[69:16]) + 72'(prod[15]);
  assign ph_sum = ((t16 < 0) != (mk < 0)) ? 72'(mh) - $signed(hterm)
                                          : 72'(mh) + $signed(hterm);
  assign idx_ext = 32'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      point_count     <= '0;
      overflow_flag   <= 1'b0;
      search_patience <= ppp_pkg::PATIENCE_RESET;
      m_tvalid        <= 1'b0;
      rv1             <= 1'b0;
      rv2             <= 1'b0;
      stop            <= 1'b0;
    end else begin
      if (cfg_we) begin
        search_patience <= cfg_wdata;
      end
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      rv1 <= issue;
      ri1 <= ia[AW-1:0];
      rv2 <= rv1;
      ri2 <= ri1;
      if (issue) begin
        ia <= ia + CW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (cnt_eff < CW'(MAX_POINTS)) begin
                point_count <= cnt_eff + CW'(1);
                if (s_tuser[1]) begin
                  overflow_flag <= 1'b0;
                end
              end else begin
                point_count   <= cnt_eff;
                overflow_flag <= 1'b1;
              end
            end else begin
              qx       <= s_tdata[31:0];
              qy       <= s_tdata[63:32];
              ia       <= '0;
              stop     <= 1'b0;
              cnt      <= '0;
              best_idx <= '0;
              if (point_count == '0) begin
                res_valid <= 1'b0;
                mx        <= '0;
                my        <= '0;
                mh        <= '0;
                mk        <= '0;
                px        <= '0;
                py        <= '0;
                t16       <= '0;
                state     <= ST_OUT;
              end else begin
                res_valid <= 1'b1;
                state     <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (rv2 && !stop) begin
            if (improve) begin
              best_dist <= sq_dist;
              best_idx  <= ri2;
            end
            cnt <= cnt_new;
            if (cnt_new > 11'(search_patience)) begin
              stop <= 1'b1;
            end
          end
          // drop points still in flight once the scan has stopped
          if (stop || (ia == point_count && !rv1 && !rv2)) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_LATCH;
        ST_LATCH: begin
          mx    <= rd_data.x;
          my    <= rd_data.y;
          mh    <= rd_data.heading;
          mk    <= rd_data.kappa;
          state <= ST_TRIG;
        end
        ST_TRIG: begin
          if (trig.done) begin
            c28   <= 31'(trig.cos_v >>> 2);
            s28   <= 31'(trig.sin_v >>> 2);
            state <= ST_MDX;
          end
        end
        ST_MDX: state <= ST_MDY;
        ST_MDY: begin
          acc   <= prod;
          state <= ST_TSUM;
        end
        ST_TSUM: begin
          t16   <= tsum[63:28];
          state <= ST_MTC;
        end
        ST_MTC: state <= ST_MTS;
        ST_MTS: begin
          px    <= ppp_pkg::sat32(px_sum);
          state <= ST_MMAG;
        end
        ST_MMAG: begin
          py    <= ppp_pkg::sat32(py_sum);
          state <= ST_PH;
        end
        ST_PH: begin
          mh    <= mh;
          acc   <= 70'(ppp_pkg::sat32(ph_sum));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, mk, (res_valid ? acc[31:0] : 32'b0), py, px, mh, my,
                         mx, idx_ext[9:0]};
            m_tuser  <= {overflow_flag, res_valid};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> point_count == CW'(MAX_POINTS))
    else $error("overflow flagged while store not full");

  a_match_in_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LATCH) |-> (CW'(best_idx) < point_count))
    else $error("match index outside loaded path");

  a_busy_during_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIG) |-> !s_tready)
    else $error("input taken while projection in progress");
`endif

endmodule
